/* rtl/cc20_pkg.sv */
// cc20_pkg: shared types, rotate amounts and the half quarter-round function
// for the ChaCha block pipeline. No dependencies.
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  // rotate amounts, first and second half of a quarter-round
  localparam int unsigned ROT_D_FIRST  = 16;
  localparam int unsigned ROT_B_FIRST  = 12;
  localparam int unsigned ROT_D_SECOND = 8;
  localparam int unsigned ROT_B_SECOND = 7;
  localparam int unsigned WORD_BITS    = 32;

  function automatic word_t rotl(input word_t x, input int unsigned r);
    return (x << r) | (x >> (WORD_BITS - r));
  endfunction

  // a += b; d ^= a; d <<<= rd; c += d; b ^= c; b <<<= rb
  function automatic quad_t half_qr(input quad_t q, input int unsigned rd,
                                    input int unsigned rb);
    quad_t o;
    o.a = q.a + q.b;
    o.d = rotl(q.d ^ o.a, rd);
    o.c = q.c + o.d;
    o.b = rotl(q.b ^ o.c, rb);
    return o;
  endfunction

endpackage

/* rtl/cc20_in_if.sv */
// cc20_in_if: input channel, valid/ready plus the eight 64-bit state fields.
// No dependencies.
interface cc20_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] in_words_0_1;
  logic [63:0] in_words_2_3;
  logic [63:0] in_words_4_5;
  logic [63:0] in_words_6_7;
  logic [63:0] in_words_8_9;
  logic [63:0] in_words_10_11;
  logic [63:0] in_words_12_13;
  logic [63:0] in_words_14_15;

  modport source (
    output valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
           in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
    input  ready
  );
  modport sink (
    input  valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
           in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
    output ready
  );
endinterface

/* rtl/cc20_out_if.sv */
// cc20_out_if: output channel, valid/ready plus the eight 64-bit result fields.
// No dependencies.
interface cc20_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_words_0_1;
  logic [63:0] out_words_2_3;
  logic [63:0] out_words_4_5;
  logic [63:0] out_words_6_7;
  logic [63:0] out_words_8_9;
  logic [63:0] out_words_10_11;
  logic [63:0] out_words_12_13;
  logic [63:0] out_words_14_15;

  modport source (
    output valid, out_words_0_1, out_words_2_3, out_words_4_5, out_words_6_7,
           out_words_8_9, out_words_10_11, out_words_12_13, out_words_14_15,
    input  ready
  );
  modport sink (
    input  valid, out_words_0_1, out_words_2_3, out_words_4_5, out_words_6_7,
           out_words_8_9, out_words_10_11, out_words_12_13, out_words_14_15,
    output ready
  );
endinterface

/* rtl/chacha20_block_function_top.sv */
// ChaCha block function, fully unrolled pipeline.
// Each double round is four half quarter-round stages, and the feedforward add
// follows them as the output register.
// Throughput: one block per cycle; the whole pipeline advances together and
// holds when the output register is full and its beat is not taken.
// Reset clears only the stage valid bits; no data state is kept between blocks.
module chacha20_block_function_top #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic              clk,
  input  logic              rst,
  cc20_in_if.sink           in_ch,
  cc20_out_if.source        out_ch
);

  // four stages per double round: column first/second half, diagonal first/second half
  localparam int NSTAGE = 4 * DOUBLE_ROUNDS;

  logic             en;
  logic             valid_chain [NSTAGE+1];
  cc20_pkg::state_t work_chain  [NSTAGE+1];
  cc20_pkg::state_t init_chain  [NSTAGE+1];
  logic             res_valid;
  cc20_pkg::state_t res_state;

  // Global advance: move when the output register is empty or being drained.
  // The input beat is taken on the same condition, so nothing is dropped or doubled.
  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;

  // Field i holds word 2i low, word 2i+1 high; the packed state matches directly.
  assign valid_chain[0] = in_ch.valid;
  assign work_chain[0]  = {in_ch.in_words_14_15, in_ch.in_words_12_13,
                           in_ch.in_words_10_11, in_ch.in_words_8_9,
                           in_ch.in_words_6_7,   in_ch.in_words_4_5,
                           in_ch.in_words_2_3,   in_ch.in_words_0_1};
  assign init_chain[0]  = work_chain[0];

  // Round stages; the original state rides along for the final feedforward.
  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    cc20_round_stage #(
      .DIAG   ((s % 4) >= 2),
      .SECOND ((s % 2) == 1)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid_chain[s]),
      .in_work   (work_chain[s]),
      .in_init   (init_chain[s]),
      .out_valid (valid_chain[s+1]),
      .out_work  (work_chain[s+1]),
      .out_init  (init_chain[s+1])
    );
  end

  // Feedforward add doubles as the output register.
  cc20_feedforward u_ff (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (valid_chain[NSTAGE]),
    .in_work   (work_chain[NSTAGE]),
    .in_init   (init_chain[NSTAGE]),
    .out_valid (res_valid),
    .out_sum   (res_state)
  );

  assign out_ch.valid           = res_valid;
  assign out_ch.out_words_0_1   = res_state[1:0];
  assign out_ch.out_words_2_3   = res_state[3:2];
  assign out_ch.out_words_4_5   = res_state[5:4];
  assign out_ch.out_words_6_7   = res_state[7:6];
  assign out_ch.out_words_8_9   = res_state[9:8];
  assign out_ch.out_words_10_11 = res_state[11:10];
  assign out_ch.out_words_12_13 = res_state[13:12];
  assign out_ch.out_words_14_15 = res_state[15:14];

endmodule

/* rtl/cc20_round_stage.sv */
// cc20_round_stage: one pipeline stage doing half of four parallel
// quarter-rounds (column or diagonal). Depends on cc20_pkg.
module cc20_round_stage #(
  parameter bit DIAG   = 1'b0,
  parameter bit SECOND = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cc20_pkg::state_t in_work,
  input  cc20_pkg::state_t in_init,
  output logic             out_valid,
  output cc20_pkg::state_t out_work,
  output cc20_pkg::state_t out_init
);

  localparam int unsigned ROT_D = SECOND ? cc20_pkg::ROT_D_SECOND : cc20_pkg::ROT_D_FIRST;
  localparam int unsigned ROT_B = SECOND ? cc20_pkg::ROT_B_SECOND : cc20_pkg::ROT_B_FIRST;

  cc20_pkg::state_t work_next;

  for (genvar q = 0; q < 4; q++) begin : g_qr
    localparam int IA = q;
    localparam int IB = 4 + (DIAG ? (q + 1) % 4 : q);
    localparam int IC = 8 + (DIAG ? (q + 2) % 4 : q);
    localparam int ID = 12 + (DIAG ? (q + 3) % 4 : q);
    cc20_pkg::quad_t qin;
    cc20_pkg::quad_t qout;
    assign qin.a = in_work[IA];
    assign qin.b = in_work[IB];
    assign qin.c = in_work[IC];
    assign qin.d = in_work[ID];
    assign qout  = cc20_pkg::half_qr(qin, ROT_D, ROT_B);
    assign work_next[IA] = qout.a;
    assign work_next[IB] = qout.b;
    assign work_next[IC] = qout.c;
    assign work_next[ID] = qout.d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
      out_init <= in_init;
    end
  end

endmodule

/* rtl/cc20_feedforward.sv */
// cc20_feedforward: final stage, adds the input state back word by word and
// holds the result for the output channel. Depends on cc20_pkg.
module cc20_feedforward (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cc20_pkg::state_t in_work,
  input  cc20_pkg::state_t in_init,
  output logic             out_valid,
  output cc20_pkg::state_t out_sum
);

  cc20_pkg::state_t sum_next;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sum_next[i] = in_work[i] + in_init[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum <= sum_next;
    end
  end

endmodule
